// File: src/first_fit_heap_allocator_defines.svh
// Assertion macros for the first-fit heap allocator.
// Included by the RTL files that carry concurrent checks; needs nothing else.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every rising clock edge outside reset.
`define FFHA_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("allocator check failed");
// Consequent must hold in the cycle the antecedent holds.
`define FFHA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("allocator check failed");
`else
`define FFHA_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define FFHA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: src/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies; the interfaces, the remainder unit, the cell and the allocator use it.
`default_nettype none
package ffha_pkg;

  localparam int MAX_BLOCKS   = 32;
  localparam int HEADER_BYTES = 12;
  localparam int WORD_BYTES   = 4;
  localparam int OFFSET_BITS  = 24;

  localparam int IDX_W   = $clog2(MAX_BLOCKS);
  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 25;
  localparam int ALIGN_W = 24;
  localparam int OFF_W   = OFFSET_BITS;
  localparam int LEN_W   = 25;
  localparam int NEED_W  = 27;
  localparam int DVD_W   = ADDR_W + 1;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_ALIGNED = 2'd2,
    ACT_RESIZE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_NOFIT   = 2'd1,
    STS_FULL    = 2'd2,
    STS_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_HEAP_BASE = 1'b0,
    CFG_HEAP_SIZE = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_INS  = 2'd1,
    SH_DEL  = 2'd2
  } shift_e;

  typedef enum logic [0:0] {
    KEY_FIT  = 1'b0,
    KEY_USED = 1'b1
  } key_e;

  typedef enum logic [4:0] {
    S_IDLE, S_A_SRCH, S_A_CALC, S_A_PTR, S_A_DGO, S_A_DIV, S_A_RED, S_A_AL,
    S_A_CHK, S_A_SPLIT, S_A_TRIM, S_R_SRCH, S_R_RD0, S_R_RD1, S_R_RD2,
    S_R_MRG, S_R_DEL2, S_Z_SRCH, S_Z_RD, S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [ADDR_W-1:0]  block_address;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] alignment;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
    logic [SIZE_W-1:0] free_bytes;
    logic [SIZE_W-1:0] copy_bytes;
    logic              moved;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    logic             free;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } entry_t;

  localparam entry_t RESET_ENT = '{valid: 1'b1, free: 1'b1, off: '0,
                                   len: LEN_W'(65536)};

  // Broadcast to every slot of the table in each cycle.
  typedef struct packed {
    logic              init;
    logic [LEN_W-1:0]  init_len;
    shift_e            shift;
    logic [IDX_W-1:0]  pos;
    entry_t            ins_ent;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    entry_t            wr_ent;
    key_e              key;
    logic [NEED_W-1:0] need;
    logic [OFF_W-1:0]  tgt_off;
    logic              tgt_ok;
  } cell_cmd_t;

endpackage
`default_nettype wire

// File: src/ffha_if.sv
// Request and response channel interfaces of the heap allocator.
// Payload types come from ffha_pkg.
`default_nettype none
interface ffha_req_if;
  logic          valid;
  logic          ready;
  ffha_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ffha_rsp_if;
  logic          valid;
  logic          ready;
  ffha_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: src/ffha_div.sv
// Bit-serial remainder unit: one dividend bit per cycle.
// Uses ffha_pkg widths.
`default_nettype none
module ffha_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [ffha_pkg::DVD_W-1:0]    dividend_i,
  input  wire logic [ffha_pkg::ALIGN_W-1:0]  divisor_i,
  output logic                               done_o,
  output logic [ffha_pkg::ALIGN_W-1:0]       rem_o
);
  import ffha_pkg::*;

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic               busy_q, done_q;
  logic [STEP_W-1:0]  step_q;
  logic [DVD_W-1:0]   dvd_q;
  logic [ALIGN_W-1:0] dsr_q, rem_q;
  logic [ALIGN_W:0]   trial;

  assign trial = {rem_q, dvd_q[DVD_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_q <= ALIGN_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_q <= trial[ALIGN_W-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// File: src/ffha_cell.sv
// One slot of the address-sorted block table; shifts with its neighbors.
// Uses ffha_pkg types.
`default_nettype none
module ffha_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [ffha_pkg::IDX_W-1:0] idx_i,
  input  wire ffha_pkg::cell_cmd_t       cmd_i,
  input  wire ffha_pkg::entry_t          left_i,
  input  wire ffha_pkg::entry_t          right_i,
  output ffha_pkg::entry_t               ent_o,
  output logic                           hit_o
);
  import ffha_pkg::*;

  entry_t ent_q, ent_d;

  always_comb begin
    ent_d = ent_q;
    priority if (cmd_i.init) begin
      ent_d = '0;
      if (idx_i == '0) begin
        ent_d.valid = 1'b1;
        ent_d.free  = 1'b1;
        ent_d.len   = cmd_i.init_len;
      end
    end else if (cmd_i.shift == SH_INS && idx_i > cmd_i.pos) begin
      ent_d = left_i;
    end else if (cmd_i.shift == SH_INS && idx_i == cmd_i.pos) begin
      ent_d = cmd_i.ins_ent;
    end else if (cmd_i.shift == SH_DEL && idx_i >= cmd_i.pos) begin
      ent_d = right_i;
    end else if (cmd_i.wr_en && idx_i == cmd_i.wr_idx) begin
      ent_d = cmd_i.wr_ent;
    end else begin
      ent_d = ent_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= (idx_i == '0) ? RESET_ENT : '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  always_comb begin
    unique case (cmd_i.key)
      KEY_FIT:  hit_o = ent_q.valid && ent_q.free &&
                        ({2'b0, ent_q.len} >= cmd_i.need);
      KEY_USED: hit_o = ent_q.valid && !ent_q.free && cmd_i.tgt_ok &&
                        (ent_q.off == cmd_i.tgt_off);
      default:  hit_o = 1'b0;
    endcase
  end

  assign ent_o = ent_q;

endmodule
`default_nettype wire

// File: src/first_fit_heap_allocator.sv
// First-fit heap allocator. A row of MAX_BLOCKS table slots holds the heap's
// blocks sorted by address (offset, length with header, free mark); every slot
// compares itself against a broadcast key, so a first-fit or address search
// is one compare across the whole row, and an insert or delete is one shift of
// the whole row. One request is worked at a time. An aligned allocate whose
// alignment exceeds the word size also runs the bit-serial remainder unit (one
// bit of the 33-bit address per cycle) and then subtract steps that bring the
// offset below the alignment. A result waits in an output register, so a new
// request is taken while it is pending. Writing heap_size reloads the table
// with a single free block; configuration is only to be written while no
// request is in work.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  ffha_req_if.sink               req_i,
  ffha_rsp_if.source             rsp_o,
  input  wire logic              cfg_we_i,
  input  wire logic [0:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_wdata_i
);
  import ffha_pkg::*;

  localparam int DIFF_W = ADDR_W + 2;
  localparam logic [NEED_W-1:0] WMASK = ~NEED_W'(WORD_BYTES - 1);
  localparam logic [LEN_W-1:0] SIZE_LIM = LEN_W'(1 << OFFSET_BITS);

  state_e state_q, state_d;

  // table row
  entry_t          ents [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] hits;
  cell_cmd_t       cmd;

  // control state
  logic [CNT_W-1:0]  count_q;
  logic [LEN_W-1:0]  free_q;
  logic [ADDR_W-1:0] base_q;
  logic              rsp_valid_q;
  rsp_t              rsp_q;

  // request context
  logic [ADDR_W-1:0]  addr_q;
  logic [SIZE_W-1:0]  size_q;
  logic [ALIGN_W-1:0] align_q;
  logic [NEED_W-1:0]  need_q;
  logic [OFF_W-1:0]   tgt_off_q;
  logic               tgt_ok_q;
  status_e            sts_q;
  logic [ADDR_W-1:0]  res_q;
  logic [SIZE_W-1:0]  copy_q;
  logic               mv_q;

  // work registers
  logic [IDX_W-1:0]   idx_q, j_q;
  entry_t             cur_q, prv_q, nxt_q;
  logic               split_q, trim_q, p_q, n_q;
  logic [OFF_W-1:0]   uoff_q;
  logic [LEN_W-1:0]   ulen_q, t_q, front_q;
  logic [ADDR_W:0]    ptr_q, al_q;
  logic [ALIGN_W-1:0] pad_q;

  logic               req_fire, any_hit, div_start, div_done, full;
  logic [IDX_W-1:0]   first_idx, rd_idx;
  entry_t             rd_ent;
  logic [ALIGN_W-1:0] div_rem, align_eff;
  logic [NEED_W-1:0]  need_plain, need_algn;
  logic [DIFF_W-1:0]  diff;
  logic [LEN_W-1:0]   cfg_len, oldsz;
  logic               calc_split;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // ---- slot row ----
  for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_slot
    entry_t left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = ents[g-1];
    end
    if (g == MAX_BLOCKS - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = ents[g+1];
    end
    ffha_cell u_slot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .ent_o   (ents[g]),
      .hit_o   (hits[g])
    );
  end

  // first hit from the low end of the table
  always_comb begin
    first_idx = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (hits[i]) first_idx = IDX_W'(i);
    end
  end
  assign any_hit = |hits;

  // single read port into the row
  always_comb begin
    unique case (state_q)
      S_R_RD1: rd_idx = idx_q - IDX_W'(1);
      S_R_RD2: rd_idx = idx_q + IDX_W'(1);
      default: rd_idx = idx_q;
    endcase
  end
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (rd_idx == IDX_W'(i)) rd_ent = ents[i];
    end
  end

  // ---- remainder unit for aligned allocate ----
  ffha_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ptr_q),
    .divisor_i  (align_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // ---- request decode ----
  assign align_eff = (req_i.payload.action == ACT_ALIGNED &&
                      req_i.payload.alignment > ALIGN_W'(WORD_BYTES)) ?
                     req_i.payload.alignment : '0;
  assign need_plain = (NEED_W'(req_i.payload.request_size) +
                       NEED_W'(HEADER_BYTES + WORD_BYTES - 1)) & WMASK;
  assign need_algn  = (NEED_W'(req_i.payload.request_size) + NEED_W'(align_eff) +
                       NEED_W'(2 * HEADER_BYTES + WORD_BYTES - 1)) & WMASK;
  // target offset of a data address, valid only inside the offset range
  assign diff = {2'b0, req_i.payload.block_address} - {2'b0, base_q} -
                DIFF_W'(HEADER_BYTES);

  assign cfg_len = (cfg_wdata_i[LEN_W-1:0] > SIZE_LIM) ? SIZE_LIM :
                   cfg_wdata_i[LEN_W-1:0];

  assign calc_split = ({3'b0, rd_ent.len} >= ({1'b0, need_q} + (NEED_W+1)'(HEADER_BYTES)));
  assign oldsz = (rd_ent.len >= LEN_W'(HEADER_BYTES)) ?
                 rd_ent.len - LEN_W'(HEADER_BYTES) : '0;
  assign full = ((CNT_W+1)'(count_q) + (CNT_W+1)'(split_q) + (CNT_W+1)'(trim_q)) >
                (CNT_W+1)'(MAX_BLOCKS);

  // ---- next state ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          unique case (action_e'(req_i.payload.action))
            ACT_ALLOC, ACT_ALIGNED: state_d = S_A_SRCH;
            ACT_RELEASE: state_d = (req_i.payload.block_address == '0) ? S_DONE : S_R_SRCH;
            ACT_RESIZE: begin
              priority if (req_i.payload.block_address == '0) state_d = S_A_SRCH;
              else if (req_i.payload.request_size == '0)       state_d = S_R_SRCH;
              else                                             state_d = S_Z_SRCH;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_A_SRCH:  state_d = any_hit ? S_A_CALC : S_DONE;
      S_A_CALC:  state_d = S_A_PTR;
      S_A_PTR:   state_d = (align_q != '0) ? S_A_DGO : S_A_CHK;
      S_A_DGO:   state_d = S_A_DIV;
      S_A_DIV:   state_d = div_done ? S_A_RED : S_A_DIV;
      S_A_RED:   state_d = (t_q >= LEN_W'(align_q)) ? S_A_RED : S_A_AL;
      S_A_AL:    state_d = S_A_CHK;
      S_A_CHK:   state_d = full ? S_DONE : S_A_SPLIT;
      S_A_SPLIT: state_d = trim_q ? S_A_TRIM : (mv_q ? S_R_SRCH : S_DONE);
      S_A_TRIM:  state_d = mv_q ? S_R_SRCH : S_DONE;
      S_R_SRCH:  state_d = any_hit ? S_R_RD0 : S_DONE;
      S_R_RD0:   state_d = S_R_RD1;
      S_R_RD1:   state_d = S_R_RD2;
      S_R_RD2:   state_d = S_R_MRG;
      S_R_MRG:   state_d = (p_q && n_q) ? S_R_DEL2 : S_DONE;
      S_R_DEL2:  state_d = S_DONE;
      S_Z_SRCH:  state_d = any_hit ? S_Z_RD : S_DONE;
      S_Z_RD:    state_d = ({1'b0, oldsz} >= {1'b0, size_q}) ? S_DONE : S_A_SRCH;
      S_DONE:    state_d = (!rsp_valid_q || rsp_o.ready) ? S_IDLE : S_DONE;
      default:   state_d = S_IDLE;
    endcase
  end

  // ---- row commands and unit start ----
  always_comb begin
    cmd          = '0;
    cmd.init     = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_HEAP_SIZE);
    cmd.init_len = cfg_len;
    cmd.key      = (state_q == S_A_SRCH) ? KEY_FIT : KEY_USED;
    cmd.need     = need_q;
    cmd.tgt_off  = tgt_off_q;
    cmd.tgt_ok   = tgt_ok_q;
    div_start    = (state_q == S_A_DGO);
    unique case (state_q)
      S_A_SPLIT: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_idx = idx_q;
        cmd.wr_ent = cur_q;
        if (split_q) begin
          // free part stays in front, used tail goes in after it
          cmd.wr_ent.len = cur_q.len - ulen_q;
          cmd.shift      = SH_INS;
          cmd.pos        = idx_q + IDX_W'(1);
          cmd.ins_ent    = '{valid: 1'b1, free: 1'b0, off: uoff_q, len: ulen_q};
        end else begin
          cmd.wr_ent.free = 1'b0;
        end
      end
      S_A_TRIM: begin
        // front of the block goes back as free, aligned part after it
        cmd.wr_en   = 1'b1;
        cmd.wr_idx  = j_q;
        cmd.wr_ent  = '{valid: 1'b1, free: 1'b1, off: uoff_q, len: front_q};
        cmd.shift   = SH_INS;
        cmd.pos     = j_q + IDX_W'(1);
        cmd.ins_ent = '{valid: 1'b1, free: 1'b0,
                        off: uoff_q + OFF_W'(front_q), len: ulen_q - front_q};
      end
      S_R_MRG: begin
        cmd.wr_en = 1'b1;
        priority if (p_q) begin
          cmd.wr_idx     = idx_q - IDX_W'(1);
          cmd.wr_ent     = prv_q;
          cmd.wr_ent.len = prv_q.len + cur_q.len + (n_q ? nxt_q.len : '0);
          cmd.shift      = SH_DEL;
          cmd.pos        = idx_q;
        end else if (n_q) begin
          cmd.wr_idx      = idx_q;
          cmd.wr_ent      = cur_q;
          cmd.wr_ent.free = 1'b1;
          cmd.wr_ent.len  = cur_q.len + nxt_q.len;
          cmd.shift       = SH_DEL;
          cmd.pos         = idx_q + IDX_W'(1);
        end else begin
          cmd.wr_idx      = idx_q;
          cmd.wr_ent      = cur_q;
          cmd.wr_ent.free = 1'b1;
        end
      end
      S_R_DEL2: begin
        cmd.shift = SH_DEL;
        cmd.pos   = idx_q;
      end
      default: ;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CNT_W'(1);
      free_q      <= RESET_ENT.len;
      base_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_HEAP_BASE: base_q <= cfg_wdata_i;
          CFG_HEAP_SIZE: begin
            count_q <= CNT_W'(1);
            free_q  <= cfg_len;
          end
          default: ;
        endcase
      end
      unique case (state_q)
        S_A_SPLIT: begin
          count_q <= count_q + CNT_W'(split_q);
          free_q  <= free_q - (split_q ? ulen_q : cur_q.len);
        end
        S_A_TRIM: begin
          count_q <= count_q + CNT_W'(1);
          free_q  <= free_q + front_q;
        end
        S_R_MRG: begin
          count_q <= count_q - CNT_W'(p_q || n_q);
          free_q  <= free_q + cur_q.len;
        end
        S_R_DEL2: count_q <= count_q - CNT_W'(1);
        default: ;
      endcase
      if (rsp_o.ready) rsp_valid_q <= 1'b0;
      if (state_q == S_DONE && (!rsp_valid_q || rsp_o.ready)) rsp_valid_q <= 1'b1;
    end
  end

  // ---- work registers ----
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          addr_q    <= req_i.payload.block_address;
          size_q    <= req_i.payload.request_size;
          align_q   <= align_eff;
          need_q    <= (align_eff != '0) ? need_algn : need_plain;
          tgt_off_q <= diff[OFF_W-1:0];
          tgt_ok_q  <= !diff[DIFF_W-1] && (diff[DIFF_W-2:OFF_W] == '0);
          sts_q     <= STS_DONE;
          res_q     <= '0;
          copy_q    <= '0;
          mv_q      <= 1'b0;
        end
      end
      S_A_SRCH: begin
        idx_q <= first_idx;
        if (!any_hit) sts_q <= STS_NOFIT;
      end
      S_A_CALC: begin
        cur_q   <= rd_ent;
        split_q <= calc_split;
        trim_q  <= 1'b0;
        if (calc_split) begin
          ulen_q <= need_q[LEN_W-1:0];
          uoff_q <= rd_ent.off + OFF_W'(rd_ent.len - need_q[LEN_W-1:0]);
        end else begin
          ulen_q <= rd_ent.len;
          uoff_q <= rd_ent.off;
        end
      end
      S_A_PTR: ptr_q <= {1'b0, base_q} + (ADDR_W+1)'(uoff_q) + (ADDR_W+1)'(HEADER_BYTES);
      S_A_DIV: begin
        if (div_done) begin
          t_q    <= LEN_W'(div_rem) + LEN_W'(HEADER_BYTES);
          trim_q <= (div_rem != '0);
        end
      end
      S_A_RED: begin
        // bring (ptr + header) mod alignment below the alignment
        if (t_q >= LEN_W'(align_q)) begin
          t_q <= t_q - LEN_W'(align_q);
        end else begin
          pad_q <= (t_q == '0) ? '0 : align_q - t_q[ALIGN_W-1:0];
        end
      end
      S_A_AL: begin
        al_q    <= ptr_q + (ADDR_W+1)'(HEADER_BYTES) + (ADDR_W+1)'(pad_q);
        front_q <= LEN_W'(pad_q) + LEN_W'(HEADER_BYTES);
      end
      S_A_CHK: begin
        if (full) begin
          sts_q <= STS_FULL;
        end else begin
          res_q <= trim_q ? al_q[ADDR_W-1:0] : ptr_q[ADDR_W-1:0];
        end
        j_q <= split_q ? idx_q + IDX_W'(1) : idx_q;
      end
      S_R_SRCH: begin
        idx_q <= first_idx;
        if (!any_hit) sts_q <= STS_UNKNOWN;
      end
      S_R_RD0: cur_q <= rd_ent;
      S_R_RD1: begin
        prv_q <= rd_ent;
        p_q   <= (idx_q != '0) && rd_ent.valid && rd_ent.free;
      end
      S_R_RD2: begin
        nxt_q <= rd_ent;
        n_q   <= (({1'b0, idx_q} + CNT_W'(1)) < count_q) && rd_ent.valid && rd_ent.free;
      end
      S_Z_SRCH: begin
        idx_q <= first_idx;
        if (!any_hit) sts_q <= STS_UNKNOWN;
      end
      S_Z_RD: begin
        if ({1'b0, oldsz} >= {1'b0, size_q}) begin
          res_q <= addr_q;
        end else begin
          copy_q <= oldsz;
          mv_q   <= 1'b1;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_q.result_address <= (sts_q == STS_DONE) ? res_q : '0;
          rsp_q.status         <= sts_q;
          rsp_q.free_bytes     <= free_q;
          rsp_q.copy_bytes     <= (sts_q == STS_DONE) ? copy_q : '0;
          rsp_q.moved          <= (sts_q == STS_DONE) && mv_q;
        end
      end
      default: ;
    endcase
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // ---- checks ----
  `FFHA_ASSERT_ALWAYS(a_count_range, clk_i, rst_ni, (count_q != '0) && (count_q <= CNT_W'(MAX_BLOCKS)))
  `FFHA_ASSERT_ALWAYS(a_free_bound, clk_i, rst_ni, free_q <= SIZE_LIM)
  `FFHA_ASSERT_IMPLY(a_fail_clean, clk_i, rst_ni, rsp_valid_q && (rsp_q.status != STS_DONE), (rsp_q.result_address == '0) && !rsp_q.moved)
  `FFHA_ASSERT_IMPLY(a_release_used, clk_i, rst_ni, state_q == S_R_MRG, cur_q.valid && !cur_q.free)

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the first-fit heap allocator.
// Needs ffha_pkg, the ffha_req_if/ffha_rsp_if interfaces and the allocator RTL.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [31:0] cfg_wdata_i;

  ffha_req_if req_ch ();
  ffha_rsp_if rsp_ch ();

  first_fit_heap_allocator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch.sink),
    .rsp_o       (rsp_ch.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block table: address-sorted entries, length includes header.
  // ---------------------------------------------------------------------------
  logic [31:0] heap_base_sh;
  logic [31:0] heap_size_sh;
  logic [31:0] blk_off [MAX_BLOCKS];
  logic [31:0] blk_len [MAX_BLOCKS];
  bit          blk_free[MAX_BLOCKS];
  int          blk_cnt;
  int unsigned free_sum;

  req_t        pending_req_q[$];   // requests waiting for the driver
  rsp_t        expected_rsp_q[$];  // responses predicted, not yet seen
  logic [31:0] live_addr_q[$];     // recently handed-out data addresses

  int unsigned n_mismatch, n_checked, n_moved, n_full, n_nofit, n_unknown;
  int unsigned cycle_cnt;
  bit          hold_sender;
  int unsigned calm_left;

  function automatic longint unsigned round_to(longint unsigned x, longint unsigned a);
    if (a == 0) return x;
    return ((x + a - 1) / a) * a;
  endfunction

  function automatic void table_reload();
    for (int k = 0; k < MAX_BLOCKS; k++) begin
      blk_off[k] = '0; blk_len[k] = '0; blk_free[k] = 1'b0;
    end
    blk_len[0]  = heap_size_sh;
    blk_free[0] = 1'b1;
    blk_cnt     = 1;
    free_sum    = heap_size_sh;
  endfunction

  function automatic void table_insert(int pos, logic [31:0] o, logic [31:0] l, bit f);
    for (int k = blk_cnt; k > pos; k--) begin
      blk_off[k] = blk_off[k-1]; blk_len[k] = blk_len[k-1]; blk_free[k] = blk_free[k-1];
    end
    blk_off[pos] = o; blk_len[pos] = l; blk_free[pos] = f;
    blk_cnt++;
  endfunction

  function automatic void table_delete(int pos);
    for (int k = pos; k + 1 < blk_cnt; k++) begin
      blk_off[k] = blk_off[k+1]; blk_len[k] = blk_len[k+1]; blk_free[k] = blk_free[k+1];
    end
    blk_cnt--;
  endfunction

  function automatic void apply_config(cfg_idx_e idx, logic [31:0] val);
    longint unsigned v;
    if (idx == CFG_HEAP_BASE) begin
      heap_base_sh = val;
    end else begin
      v = val & 32'h1FF_FFFF;
      if (v > (64'd1 << OFFSET_BITS)) v = 64'd1 << OFFSET_BITS;
      heap_size_sh = v;
      table_reload();
    end
  endfunction

  // First fit, tail carve or whole block, optional aligned front give-back.
  function automatic status_e carve_block(longint unsigned size, longint unsigned align,
                                          output longint unsigned addr);
    longint unsigned need, ptr, al, front, uoff, ulen;
    int  i, j;
    bit  split, trim;
    addr = 0;
    i = -1;
    if (align <= WORD_BYTES) align = 0;
    if (align == 0) need = round_to(size + HEADER_BYTES, WORD_BYTES);
    else            need = round_to(size + align + 2 * HEADER_BYTES, WORD_BYTES);
    for (int k = 0; k < blk_cnt; k++)
      if (blk_free[k] && blk_len[k] >= need) begin
        i = k;
        break;
      end
    if (i < 0) return STS_NOFIT;
    split = blk_len[i] >= need + HEADER_BYTES;
    if (split) begin
      ulen = need;
      uoff = (blk_off[i] + blk_len[i] - ulen) & 32'hFFFF_FFFF;
    end else begin
      ulen = blk_len[i];
      uoff = blk_off[i];
    end
    ptr  = longint'(heap_base_sh) + uoff + HEADER_BYTES;
    trim = align != 0 && round_to(ptr, align) != ptr;
    if (blk_cnt + int'(split) + int'(trim) > MAX_BLOCKS) return STS_FULL;
    if (!split) begin
      blk_free[i] = 1'b0;
      free_sum   -= blk_len[i];
      j = i;
    end else begin
      blk_len[i] -= need;
      table_insert(i + 1, blk_off[i] + blk_len[i], need, 1'b0);
      free_sum   -= need;
      j = i + 1;
    end
    if (!trim) begin
      addr = ptr;
      return STS_DONE;
    end
    al    = round_to(ptr + HEADER_BYTES, align);
    front = al - ptr;
    table_insert(j + 1, uoff + front, ulen - front, 1'b0);
    blk_len[j]  = front;
    blk_free[j] = 1'b1;
    free_sum   += front;
    addr = al;
    return STS_DONE;
  endfunction

  function automatic int find_used(longint unsigned addr);
    for (int k = 0; k < blk_cnt; k++)
      if (!blk_free[k] && longint'(heap_base_sh) + blk_off[k] + HEADER_BYTES == addr)
        return k;
    return -1;
  endfunction

  function automatic status_e give_back(longint unsigned addr);
    int f;
    if (addr == 0) return STS_DONE;
    f = find_used(addr);
    if (f < 0) return STS_UNKNOWN;
    blk_free[f] = 1'b1;
    free_sum   += blk_len[f];
    if (f > 0 && blk_free[f-1]) begin
      blk_len[f-1] += blk_len[f];
      table_delete(f);
      f--;
    end
    if (f + 1 < blk_cnt && blk_free[f+1]) begin
      blk_len[f] += blk_len[f+1];
      table_delete(f + 1);
    end
    return STS_DONE;
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t            o;
    status_e         st;
    longint unsigned res, copy, oldsz;
    int              f;
    bit              mv;
    res = 0; copy = 0; mv = 1'b0; st = STS_DONE;
    case (action_e'(r.action))
      ACT_ALLOC:   st = carve_block(r.request_size, 0, res);
      ACT_RELEASE: st = give_back(r.block_address);
      ACT_ALIGNED: st = carve_block(r.request_size, r.alignment, res);
      default: begin
        if (r.block_address == 0) begin
          st = carve_block(r.request_size, 0, res);
        end else if (r.request_size == 0) begin
          st = give_back(r.block_address);
        end else begin
          f = find_used(r.block_address);
          if (f < 0) begin
            st = STS_UNKNOWN;
          end else begin
            oldsz = blk_len[f] >= HEADER_BYTES ? blk_len[f] - HEADER_BYTES : 0;
            if (oldsz >= r.request_size) begin
              res = r.block_address;
            end else begin
              st = carve_block(r.request_size, 0, res);
              if (st == STS_DONE) begin
                copy = oldsz;
                mv   = 1'b1;
                void'(give_back(r.block_address));
              end
            end
          end
        end
      end
    endcase
    if (st != STS_DONE) res = 0;
    o.result_address = res[31:0];
    o.status         = st;
    o.free_bytes     = free_sum[24:0];
    o.copy_bytes     = copy[24:0];
    o.moved          = mv;
    return o;
  endfunction

  // Mostly short gaps, a few long ones, none during a calm stretch.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_cnt, expected_rsp_q.size());
      $display("FAIL first_fit_heap_allocator");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: pops pending requests, predicts at acceptance.
  // ---------------------------------------------------------------------------
  int unsigned src_gap;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      src_gap      <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        rsp_t p;
        p = predict_response(req_ch.payload);
        expected_rsp_q.push_back(p);
        if (p.status == STS_DONE && p.result_address != 0) begin
          live_addr_q.push_back(p.result_address);
          if (live_addr_q.size() > 48) void'(live_addr_q.pop_front());
        end
        if (calm_left != 0) calm_left--;
        else if ($urandom_range(0, 40) == 0) calm_left = $urandom_range(10, 60);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (src_gap != 0) begin
          src_gap      <= src_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_req_q.size() != 0 && !hold_sender) begin
          req_ch.payload <= pending_req_q.pop_front();
          req_ch.valid   <= 1'b1;
          src_gap        <= pick_gap();
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor with random back-pressure
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_t got, want;
        got = rsp_ch.payload;
        if (expected_rsp_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected response: addr %h status %0d", got.result_address,
                     got.status);
        end else begin
          want = expected_rsp_q.pop_front();
          n_checked++;
          if (want.moved) n_moved++;
          if (want.status == STS_FULL) n_full++;
          if (want.status == STS_NOFIT) n_nofit++;
          if (want.status == STS_UNKNOWN) n_unknown++;
          if (got.result_address !== want.result_address || got.status !== want.status ||
              got.free_bytes !== want.free_bytes || got.copy_bytes !== want.copy_bytes ||
              got.moved !== want.moved) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch on response %0d:", n_checked);
              $display("  addr   exp %h got %h", want.result_address, got.result_address);
              $display("  status exp %0d got %0d", want.status, got.status);
              $display("  free   exp %0d got %0d", want.free_bytes, got.free_bytes);
              $display("  copy   exp %0d got %0d  moved exp %0b got %0b",
                       want.copy_bytes, got.copy_bytes, want.moved, got.moved);
            end
          end
        end
      end
      // mostly ready with random stalls, always ready during a calm stretch
      if (calm_left != 0) rsp_ch.ready <= 1'b1;
      else if ($urandom_range(0, 99) < 3) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 99) < 75);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic req_t make_req(action_e a, logic [31:0] addr, logic [24:0] sz,
                                    logic [23:0] al);
    req_t r;
    r.action = a; r.block_address = addr; r.request_size = sz; r.alignment = al;
    return r;
  endfunction

  task automatic push_req(req_t r);
    while (pending_req_q.size() >= 2) @(posedge clk_i);
    pending_req_q.push_back(r);
  endtask

  // Wait until nothing is queued, in flight or expected.
  task automatic wait_drained();
    while (pending_req_q.size() != 0 || req_ch.valid || expected_rsp_q.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    apply_config(idx, val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [31:0] pick_live();
    if (live_addr_q.size() == 0) return heap_base_sh + HEADER_BYTES;
    return live_addr_q[$urandom_range(0, live_addr_q.size() - 1)];
  endfunction

  function automatic logic [23:0] pick_align();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 24'd1 << $urandom_range(0, 10);
    if (r < 85) return $urandom_range(1, 300);          // not a power of two, mostly
    if (r < 93) return 24'd1 << 23;
    return $urandom;
  endfunction

  task automatic random_burst(int unsigned n);
    int unsigned smax, r;
    logic [24:0] sz;
    for (int unsigned k = 0; k < n; k++) begin
      smax = heap_size_sh / 8 + 16;
      sz   = $urandom_range(0, smax);
      r    = $urandom_range(0, 99);
      if (r < 32)      push_req(make_req(ACT_ALLOC, $urandom, sz, $urandom));
      else if (r < 57) push_req(make_req(ACT_RELEASE, pick_live(), $urandom, $urandom));
      else if (r < 72) push_req(make_req(ACT_ALIGNED, $urandom, sz, pick_align()));
      else if (r < 92) push_req(make_req(ACT_RESIZE, pick_live(),
                                         ($urandom_range(0, 9) == 0) ? 25'd0 : sz, $urandom));
      else             push_req(make_req(action_e'($urandom_range(0, 3)), $urandom,
                                         $urandom, $urandom));
      // sender holds off once until everything in flight has answered
      if (k == n / 2 && n > 100) begin
        hold_sender = 1'b1;
        while (req_ch.valid || expected_rsp_q.size() != 0) @(posedge clk_i);
        hold_sender = 1'b0;
      end
    end
  endtask

  initial begin
    logic [31:0] a0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_HEAP_BASE;
    cfg_wdata_i  = '0;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    rsp_ch.ready   = 1'b0;
    hold_sender = 1'b0;
    calm_left   = 0;
    cycle_cnt   = 0;
    n_mismatch  = 0; n_checked = 0; n_moved = 0; n_full = 0; n_nofit = 0; n_unknown = 0;
    heap_base_sh = '0;
    heap_size_sh = 32'd65536;
    table_reload();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed requests on the reset heap
    push_req(make_req(ACT_ALLOC, '0, 25'd0, 24'd0));
    push_req(make_req(ACT_ALLOC, '0, 25'd100, 24'd0));
    push_req(make_req(ACT_ALIGNED, '0, 25'd40, 24'd64));
    push_req(make_req(ACT_ALIGNED, '0, 25'd10, 24'd3));      // small alignment: plain
    push_req(make_req(ACT_ALIGNED, '0, 25'd20, 24'd24));     // not a power of two
    push_req(make_req(ACT_RELEASE, '0, 25'd0, 24'd0));       // null release
    push_req(make_req(ACT_RELEASE, 32'd12345, 25'd0, 24'd0)); // unknown address
    wait_drained();
    a0 = live_addr_q[0];
    push_req(make_req(ACT_RELEASE, a0, 25'd0, 24'd0));
    push_req(make_req(ACT_RELEASE, a0, 25'd0, 24'd0));       // already free
    push_req(make_req(ACT_RESIZE, '0, 25'd50, 24'd0));       // resize of null
    wait_drained();
    a0 = live_addr_q[$];
    push_req(make_req(ACT_RESIZE, a0, 25'd8, 24'd0));        // fits in place
    push_req(make_req(ACT_RESIZE, a0, 25'd3000, 24'd0));     // must move
    push_req(make_req(ACT_RESIZE, 32'd4, 25'd8, 24'd0));     // unknown address
    push_req(make_req(ACT_ALLOC, '0, 25'h1000000, 24'd0));   // no fit
    push_req(make_req(ACT_ALIGNED, '0, 25'd0, 24'h800000));  // huge alignment
    push_req(make_req(ACT_RESIZE, 32'hFFFF_FFFF, 25'h1FF_FFFF, 24'hFF_FFFF));
    wait_drained();
    a0 = live_addr_q[$];
    push_req(make_req(ACT_RESIZE, a0, 25'd0, 24'd0));        // resize to zero
    push_req(make_req(ACT_RESIZE, a0, 25'd60000, 24'd0));    // unknown now
    for (int k = 0; k < 34; k++)                             // fill the table
      push_req(make_req(ACT_ALLOC, '0, 25'd4, 24'd0));
    push_req(make_req(ACT_ALIGNED, '0, 25'd4, 24'd256));     // table full
    random_burst(110);
    wait_drained();

    write_reg(CFG_HEAP_BASE, 32'h1000_0000);
    write_reg(CFG_HEAP_SIZE, 32'd4096);
    random_burst(150);
    wait_drained();

    // highest base, smallest heap
    write_reg(CFG_HEAP_BASE, 32'hFFFF_FFF4);
    write_reg(CFG_HEAP_SIZE, 32'd12);
    push_req(make_req(ACT_ALLOC, '0, 25'd0, 24'd0));
    random_burst(30);
    wait_drained();

    write_reg(CFG_HEAP_BASE, 32'h0);
    write_reg(CFG_HEAP_SIZE, 32'h100_0000);                  // largest heap
    push_req(make_req(ACT_ALIGNED, '0, 25'd100, 24'h800000));
    random_burst(150);
    wait_drained();

    write_reg(CFG_HEAP_BASE, 32'h0000_48D0);
    write_reg(CFG_HEAP_SIZE, 32'd1000);
    random_burst(180);
    wait_drained();

    write_reg(CFG_HEAP_BASE, 32'hFFFF_0000);
    write_reg(CFG_HEAP_SIZE, 32'd65536);
    random_burst(200);
    wait_drained();

    write_reg(CFG_HEAP_BASE, 32'h20);
    write_reg(CFG_HEAP_SIZE, 32'd300);
    random_burst(160);

    wait_drained();
    repeat (100) @(posedge clk_i);
    if (expected_rsp_q.size() != 0) begin
      $display("%0d responses never arrived", expected_rsp_q.size());
      n_mismatch++;
    end
    $display("checked %0d responses over 7 heap settings: %0d moves, %0d no-fit,",
             n_checked, n_moved, n_nofit);
    $display("  %0d table-full, %0d unknown-address; %0d mismatches",
             n_full, n_unknown, n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASS first_fit_heap_allocator");
    end else begin
      $display("FAIL first_fit_heap_allocator");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
+incdir+src
src/ffha_pkg.sv
src/ffha_if.sv
src/ffha_div.sv
src/ffha_cell.sv
src/first_fit_heap_allocator.sv
verif/tb_top.sv
